[src/cpfi_pkg.sv]
`timescale 1ns / 1ps

package cpfi_pkg;

    // Table geometry
    localparam int MAX_POINTS = 256;
    localparam int PIDX_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = PIDX_W + 1;

    // Field widths
    localparam int FREQ_W  = 32;
    localparam int VAL_W   = 32;
    localparam int NCOMP   = 4;
    localparam int POINT_W = VAL_W * NCOMP;
    localparam int T_W     = 16;
    localparam int PCNT_W  = 9;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_POINT_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_LOW_HZ  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_HIGH_HZ = 2'd2;

    // Item kinds carried on s_tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Serial divider produces one weight bit per step
    localparam int DIV_STEPS = T_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic div_load;
        logic div_step;
        logic mul_en;
    } arith_ctl_t;

endpackage

[src/cpfi_ram.sv]
`timescale 1ns / 1ps

module cpfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/cpfi_arith.sv]
`timescale 1ns / 1ps

module cpfi_arith import cpfi_pkg::*; (
    input  logic                    aclk,
    input  arith_ctl_t              ctl,
    input  logic [FREQ_W-1:0]       num_in,
    input  logic [FREQ_W-1:0]       den_in,
    input  logic signed [VAL_W-1:0] a_in,
    input  logic signed [VAL_W-1:0] b_in,
    output logic signed [VAL_W-1:0] lerp_out
);

    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + T_W + 1;
    localparam int SHR_W  = PROD_W - T_W;
    localparam int SUM_W  = SHR_W + 1;

    logic [FREQ_W-1:0]        rem_reg;
    logic [FREQ_W-1:0]        den_reg;
    logic [T_W-1:0]           quo_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [FREQ_W:0]          rem_shl;
    logic                     rem_ge;
    logic [FREQ_W:0]          rem_sub;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;

    // restoring divide, one quotient bit per step; the remainder never
    // exceeds the divisor, so a full-scale weight comes out as all ones
    assign rem_shl = {rem_reg, 1'b0};
    assign rem_ge  = rem_shl >= {1'b0, den_reg};
    assign rem_sub = rem_shl - {1'b0, den_reg};

    assign diff = DIFF_W'(b_in) - DIFF_W'(a_in);

    always_ff @(posedge aclk) begin
        if (ctl.div_load) begin
            rem_reg <= num_in;
            den_reg <= den_in;
            quo_reg <= '0;
        end else if (ctl.div_step) begin
            rem_reg <= rem_ge ? rem_sub[FREQ_W-1:0] : rem_shl[FREQ_W-1:0];
            quo_reg <= {quo_reg[T_W-2:0], rem_ge};
        end
        if (ctl.mul_en) begin
            prod_reg <= PROD_W'(diff) * PROD_W'($signed({1'b0, quo_reg}));
        end
    end

    // arithmetic shift floors the scaled step toward minus infinity
    assign sum = SUM_W'(a_in) + SUM_W'($signed(prod_reg[PROD_W-1:T_W]));

    always_comb begin
        if (sum > SUM_W'(signed'(32'sh7fffffff))) begin
            lerp_out = 32'sh7fffffff;
        end else if (sum < SUM_W'(signed'(-32'sh80000000))) begin
            lerp_out = -32'sh80000000;
        end else begin
            lerp_out = sum[VAL_W-1:0];
        end
    end

endmodule

[src/complex_profile_freq_interpolator_unit.sv]
`timescale 1ns / 1ps
// Channel | Dir | Ports                    | Contents
// s_      | in  | tvalid tready tdata tuser| write point or query
// m_      | out | tvalid tready tdata tuser| ok flag and four Q16.16 values
// cfg_    | in  | we addr wdata            | point_count, freq_low_hz, freq_high_hz
//
// A write, or a query failing the count or range check, goes straight to done.
// A full query scans the frequency RAM one slot per cycle over the points in use
// (point_count capped at 256), then a 16-step serial divider forms the weight
// and one shared multiplier handles the four components in turn. s_tready is
// high only in the idle state.
// aresetn is synchronous, active low, and clears config and valid bits.
// A finished result waits in the output register while the next item is taken.

module complex_profile_freq_interpolator_unit import cpfi_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_index, freq_hz, in_zc_re, in_zc_im, in_tanh_re, in_tanh_im, in_valid
    input  logic [175:0]          s_tdata,
    // func
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_zc_re, out_zc_im, out_tanh_re, out_tanh_im
    output logic [127:0]          m_tdata,
    // ok
    output logic                  m_tuser
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN    = 9'b000000010,
        S_FETCH_L = 9'b000000100,
        S_FETCH_R = 9'b000001000,
        S_CAPT_R  = 9'b000010000,
        S_DIV     = 9'b000100000,
        S_MUL     = 9'b001000000,
        S_ADD     = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    typedef logic [NCOMP-1:0][VAL_W-1:0] vals_t;

    state_t state_reg, state_next;

    logic [PCNT_W-1:0]    point_count_reg;
    logic [FREQ_W-1:0]    freq_low_reg;
    logic [FREQ_W-1:0]    freq_high_reg;
    logic [MAX_POINTS-1:0] valid_reg;

    logic [FREQ_W-1:0]    f_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     scan_idx_reg;
    logic                 pipe_vld_reg;
    logic [PIDX_W-1:0]    pipe_idx_reg;
    logic                 have_l_reg, have_r_reg;
    logic [PIDX_W-1:0]    il_reg, ir_reg;
    logic [FREQ_W-1:0]    fl_reg, fr_reg;
    vals_t                a_vals_reg, b_vals_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [1:0]           comp_reg;
    logic                 res_ok_reg;
    vals_t                res_data_reg;
    logic                 m_tvalid_reg;
    logic                 m_tuser_reg;
    vals_t                m_tdata_reg;

    // input fields
    logic [7:0]         in_point_index;
    logic [FREQ_W-1:0]  in_freq_hz;
    logic [POINT_W-1:0] in_point;
    logic               in_valid;

    logic               accept;
    logic               wr_in_range;
    logic [CNT_W-1:0]   n_calc;
    logic               early_fail;
    logic [FREQ_W-1:0]  freq_rd;
    logic [POINT_W-1:0] vals_rd;
    logic [PIDX_W-1:0]  vals_rd_addr;
    logic               scan_issue;
    logic               scan_end;
    logic               hit;
    logic               coincide;
    logic               out_free;
    arith_ctl_t         actl;
    logic signed [VAL_W-1:0] lerp_out;

    assign in_point_index = s_tdata[7:0];
    assign in_freq_hz     = s_tdata[39:8];
    assign in_point       = s_tdata[167:40];
    assign in_valid       = s_tdata[168];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign wr_in_range = 32'(in_point_index) < MAX_POINTS;
    assign n_calc = (32'(point_count_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                        : CNT_W'(point_count_reg);
    assign early_fail = (n_calc == '0) || (in_freq_hz < freq_low_reg)
                        || (in_freq_hz > freq_high_reg);

    assign scan_issue = scan_idx_reg < n_reg;
    assign scan_end   = !scan_issue && !pipe_vld_reg;
    assign hit        = pipe_vld_reg && valid_reg[pipe_idx_reg];
    assign coincide   = (il_reg == ir_reg) || (fl_reg == fr_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    assign vals_rd_addr = (state_reg == S_FETCH_L) ? il_reg : ir_reg;

    cpfi_ram #(.WIDTH(FREQ_W), .DEPTH(MAX_POINTS)) u_freq_ram (
        .aclk    (aclk),
        .wr_en   (accept && (s_tuser == FUNC_WRITE) && wr_in_range),
        .wr_addr (PIDX_W'(in_point_index)),
        .wr_data (in_freq_hz),
        .rd_addr (scan_idx_reg[PIDX_W-1:0]),
        .rd_data (freq_rd)
    );

    cpfi_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_vals_ram (
        .aclk    (aclk),
        .wr_en   (accept && (s_tuser == FUNC_WRITE) && wr_in_range),
        .wr_addr (PIDX_W'(in_point_index)),
        .wr_data (in_point),
        .rd_addr (vals_rd_addr),
        .rd_data (vals_rd)
    );

    assign actl.div_load = (state_reg == S_CAPT_R);
    assign actl.div_step = (state_reg == S_DIV);
    assign actl.mul_en   = (state_reg == S_MUL);

    cpfi_arith u_arith (
        .aclk     (aclk),
        .ctl      (actl),
        .num_in   (f_reg - fl_reg),
        .den_in   (fr_reg - fl_reg),
        .a_in     (a_vals_reg[comp_reg]),
        .b_in     (b_vals_reg[comp_reg]),
        .lerp_out (lerp_out)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == FUNC_WRITE || early_fail) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = (have_l_reg && have_r_reg) ? S_FETCH_L : S_DONE;
                end
            end
            S_FETCH_L: state_next = S_FETCH_R;
            S_FETCH_R: state_next = S_CAPT_R;
            S_CAPT_R:  state_next = coincide ? S_DONE : S_DIV;
            S_DIV: begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_ADD;
            S_ADD: state_next = (comp_reg == 2'(NCOMP - 1)) ? S_DONE : S_MUL;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            freq_low_reg    <= '0;
            freq_high_reg   <= '0;
            valid_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
            pipe_vld_reg    <= 1'b0;
            have_l_reg      <= 1'b0;
            have_r_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_POINT_COUNT:  point_count_reg <= cfg_wdata[PCNT_W-1:0];
                    CFG_FREQ_LOW_HZ:  freq_low_reg    <= cfg_wdata[FREQ_W-1:0];
                    CFG_FREQ_HIGH_HZ: freq_high_reg   <= cfg_wdata[FREQ_W-1:0];
                    default: ;
                endcase
            end

            if (accept && s_tuser == FUNC_WRITE && wr_in_range) begin
                valid_reg[PIDX_W'(in_point_index)] <= in_valid;
            end

            if (accept) begin
                pipe_vld_reg <= 1'b0;
                have_l_reg   <= 1'b0;
                have_r_reg   <= 1'b0;
            end else if (state_reg == S_SCAN) begin
                pipe_vld_reg <= scan_issue;
                // left: last qualifying slot; right: first qualifying slot
                if (hit && freq_rd <= f_reg) begin
                    have_l_reg <= 1'b1;
                end
                if (hit && freq_rd >= f_reg) begin
                    have_r_reg <= 1'b1;
                end
            end

            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            f_reg        <= in_freq_hz;
            n_reg        <= n_calc;
            scan_idx_reg <= '0;
            res_data_reg <= '0;
            res_ok_reg   <= (s_tuser == FUNC_WRITE);
        end

        unique case (state_reg)
            S_SCAN: begin
                if (scan_issue) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                pipe_idx_reg <= scan_idx_reg[PIDX_W-1:0];
                if (hit && freq_rd <= f_reg) begin
                    il_reg <= pipe_idx_reg;
                    fl_reg <= freq_rd;
                end
                if (hit && freq_rd >= f_reg && !have_r_reg) begin
                    ir_reg <= pipe_idx_reg;
                    fr_reg <= freq_rd;
                end
            end
            S_FETCH_R: a_vals_reg <= vals_rd;
            S_CAPT_R: begin
                b_vals_reg  <= vals_rd;
                div_cnt_reg <= '0;
                comp_reg    <= '0;
                if (coincide) begin
                    res_ok_reg   <= 1'b1;
                    res_data_reg <= a_vals_reg;
                end
            end
            S_DIV: div_cnt_reg <= div_cnt_reg + 1'b1;
            S_ADD: begin
                comp_reg <= comp_reg + 1'b1;
                if (comp_reg == 2'(NCOMP - 1)) begin
                    // impedance real part must come out strictly positive
                    if ($signed(res_data_reg[0]) > 0) begin
                        res_ok_reg             <= 1'b1;
                        res_data_reg[comp_reg] <= lerp_out;
                    end else begin
                        res_ok_reg   <= 1'b0;
                        res_data_reg <= '0;
                    end
                end else begin
                    res_data_reg[comp_reg] <= lerp_out;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tuser_reg <= res_ok_reg;
                    m_tdata_reg <= res_data_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        have_l_reg |-> fl_reg <= f_reg)
        else $error("left neighbor above query frequency");

    a_right_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        have_r_reg |-> fr_reg >= f_reg)
        else $error("right neighbor below query frequency");

    a_scan_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> scan_idx_reg <= n_reg)
        else $error("scan index ran past point count");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) && out_free |=> m_tvalid_reg && (state_reg == S_IDLE))
        else $error("result not presented on release");

    a_lerp_needs_both: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH_L) |-> have_l_reg && have_r_reg)
        else $error("fetch started without both neighbors");

endmodule

[tb/complex_profile_freq_interpolator_unit_tb.sv]
`timescale 1ns / 1ps

module complex_profile_freq_interpolator_unit_tb;
    import cpfi_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;   // no register behind this index
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 300;
    localparam logic [31:0] FREQ_TOP       = 32'hFFFF_FFFF;

    // Same bit order as m_tdata: zc_re in the lowest bits
    typedef struct packed {
        logic [31:0] tanh_im;
        logic [31:0] tanh_re;
        logic [31:0] zc_im;
        logic [31:0] zc_re;
    } profile_vals_t;

    typedef struct packed {
        logic          ok;
        profile_vals_t v;
    } profile_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [175:0]          s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [127:0]          m_tdata;
    logic                  m_tuser;

    complex_profile_freq_interpolator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow copy of the point table and the registers
    logic [31:0]       pt_freq [MAX_POINTS];
    logic              pt_valid[MAX_POINTS];
    profile_vals_t     pt_vals [MAX_POINTS];
    logic [PCNT_W-1:0] lim_count  = '0;
    logic [31:0]       lim_f_low  = '0;
    logic [31:0]       lim_f_high = '0;

    profile_result_t expected_q[$];
    logic [31:0]     phase_freqs[$];
    int              error_count   = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              quiet_cycles  = 0;
    int              phase_plan[18] = '{4, 9, 2, 16, 256, 7, 0, 32, 1, 12, 511, 5, 20, 3, 256,
                                        8, 11, 6};

    initial forever #1 aclk = ~aclk;

    // a + floor((b - a) * w / 65536), clamped to 32 bits
    function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                          input logic [15:0] w);
        longint sa, sb, prod, r;
        sa   = $signed(a);
        sb   = $signed(b);
        prod = (sb - sa) * longint'(w);
        r    = sa + (prod >>> 16);
        if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
        if (r < -64'sh8000_0000) r = -64'sh8000_0000;
        return r[31:0];
    endfunction

    function automatic profile_result_t evaluate_profile(input logic func, input logic [7:0] slot,
            input logic [31:0] f, input profile_vals_t vals, input logic vld);
        profile_result_t res;
        profile_vals_t   a, b;
        int              n, i, lft, rgt;
        logic [31:0]     diff;
        logic [63:0]     num, den;
        logic [15:0]     w;
        res = '0;
        if (func == FUNC_WRITE) begin
            pt_freq[slot]  = f;
            pt_valid[slot] = vld;
            pt_vals[slot]  = vals;
            res.ok = 1'b1;
            return res;
        end
        n = (lim_count > MAX_POINTS) ? MAX_POINTS : int'(lim_count);
        if (n == 0 || f < lim_f_low || f > lim_f_high) return res;
        lft = -1;
        rgt = -1;
        for (i = n - 1; i >= 0 && lft < 0; i--)
            if (pt_valid[i] && pt_freq[i] <= f) lft = i;
        for (i = 0; i < n && rgt < 0; i++)
            if (pt_valid[i] && pt_freq[i] >= f) rgt = i;
        if (lft < 0 || rgt < 0) return res;
        a = pt_vals[lft];
        b = pt_vals[rgt];
        if (lft == rgt || pt_freq[lft] == pt_freq[rgt]) begin
            res.ok = 1'b1;
            res.v  = a;
            return res;
        end
        diff = f - pt_freq[lft];
        num  = {32'd0, diff} << 16;
        den  = {32'd0, pt_freq[rgt] - pt_freq[lft]};
        num  = num / den;
        w    = (num > 64'd65535) ? 16'hFFFF : num[15:0];
        res.v.zc_re   = blend(a.zc_re, b.zc_re, w);
        res.v.zc_im   = blend(a.zc_im, b.zc_im, w);
        res.v.tanh_re = blend(a.tanh_re, b.tanh_re, w);
        res.v.tanh_im = blend(a.tanh_im, b.tanh_im, w);
        if ($signed(res.v.zc_re) <= 0) return '0;
        res.ok = 1'b1;
        return res;
    endfunction

    function automatic profile_vals_t random_point_vals();
        profile_vals_t v;
        int unsigned   r;
        v = {$urandom, $urandom, $urandom, $urandom};
        r = $urandom_range(99);
        // keep most impedances positive so interpolation gets through
        if (r < 50) v.zc_re = $urandom_range(32'h00FF_FFFF, 1);
        else if (r < 80) v.zc_re = {1'b0, v.zc_re[30:0]};
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic func, input logic [7:0] slot, input logic [31:0] f,
                             input profile_vals_t vals, input logic vld);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'd0, vld, vals, f, slot};
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(evaluate_profile(func, slot, f, vals, vld));
        @(negedge aclk);
    endtask

    task automatic write_point(input logic [7:0] slot, input logic [31:0] f,
                               input profile_vals_t vals, input logic vld);
        send_item(FUNC_WRITE, slot, f, vals, vld);
    endtask

    // Unused fields of a query carry junk
    task automatic query_at(input logic [31:0] f);
        send_item(FUNC_QUERY, 8'($urandom), f, random_point_vals(), 1'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_q.size() != 0);
    endtask

    task automatic set_regs(input logic [PCNT_W-1:0] count, input logic [31:0] f_low,
                            input logic [31:0] f_high, input logic poke_spare);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_POINT_COUNT;
        cfg_wdata <= CFG_DATA_W'(count);
        @(negedge aclk);
        cfg_addr  <= CFG_FREQ_LOW_HZ;
        cfg_wdata <= f_low;
        @(negedge aclk);
        cfg_addr  <= CFG_FREQ_HIGH_HZ;
        cfg_wdata <= f_high;
        @(negedge aclk);
        if (poke_spare) begin
            cfg_addr  <= CFG_SPARE;
            cfg_wdata <= $urandom;
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        lim_count  = count;
        lim_f_low  = f_low;
        lim_f_high = f_high;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin : check_results
        profile_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            if (expected_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none actual ok %b data %h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("ok", want.ok, got.ok);
                check_field("zc_re", want.v.zc_re, got.v.zc_re);
                check_field("zc_im", want.v.zc_im, got.v.zc_im);
                check_field("tanh_re", want.v.tanh_re, got.v.tanh_re);
                check_field("tanh_im", want.v.tanh_im, got.v.tanh_im);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles = 0;
        else quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Registers still at reset: count zero
    task automatic test_empty_table();
        query_at(32'd0);
    endtask

    task automatic test_lookup_cases();
        write_point(8'd0, 32'd0, profile_vals_t'{zc_re: 32'h7FFF_FFFF, zc_im: 32'h8000_0000,
                    tanh_re: 32'h8000_0000, tanh_im: 32'h7FFF_FFFF}, 1'b1);
        write_point(8'd1, 32'd1000, profile_vals_t'{zc_re: 32'h0001_0000, zc_im: 32'hFFFF_0000,
                    tanh_re: 32'h0000_8000, tanh_im: 32'h7FFF_0000}, 1'b1);
        write_point(8'd2, 32'd1000, profile_vals_t'{zc_re: 32'h0003_0000, zc_im: 32'h0000_4000,
                    tanh_re: 32'hFFFF_C000, tanh_im: 32'h0000_0000}, 1'b1);
        write_point(8'd3, 32'd2000, profile_vals_t'{zc_re: 32'hFFFB_0000, zc_im: 32'h8000_0000,
                    tanh_re: 32'h7FFF_FFFF, tanh_im: 32'h8000_0000}, 1'b1);
        // present but unusable
        write_point(8'd4, 32'd3000, profile_vals_t'{zc_re: 32'h0010_0000, zc_im: 32'h0,
                    tanh_re: 32'h0, tanh_im: 32'h0}, 1'b0);
        write_point(8'd255, FREQ_TOP, profile_vals_t'{zc_re: 32'h7FFF_FFFF, zc_im: 32'h7FFF_FFFF,
                    tanh_re: 32'h8000_0000, tanh_im: 32'h8000_0000}, 1'b1);
        set_regs(9'd256, 32'd0, FREQ_TOP, 1'b0);
        query_at(32'd0);          // left and right are the same slot
        query_at(32'd500);        // plain interpolation
        query_at(32'd1000);       // two slots at one frequency
        query_at(32'd1500);       // impedance crosses zero
        query_at(32'd3000);       // skips the unusable slot
        query_at(32'hC000_0000);
        query_at(FREQ_TOP);
        // left point sits above the right one in the table: weight clamps
        write_point(8'd200, 32'd500, profile_vals_t'{zc_re: 32'h0002_0000, zc_im: 32'h0001_0000,
                    tanh_re: 32'hFFFF_0000, tanh_im: 32'h0000_1000}, 1'b1);
        query_at(32'd1000);
    endtask

    task automatic test_range_and_neighbours();
        set_regs(9'd3, 32'd100, 32'd1200, 1'b0);
        query_at(32'd50);
        query_at(32'd1300);
        query_at(32'd1200);       // nothing at or above in the first three slots
        query_at(32'd600);
        set_regs(9'd256, 32'd2000, 32'd1000, 1'b0);
        query_at(32'd1500);       // inverted window
        write_point(8'd0, 32'd0, random_point_vals(), 1'b0);
        set_regs(9'd256, 32'd0, FREQ_TOP, 1'b0);
        query_at(32'd400);        // nothing at or below
    endtask

    task automatic test_register_handling();
        set_regs(9'd511, 32'd0, FREQ_TOP, 1'b1);
        query_at(32'hC000_0000);
        query_at(32'h8000_0000);
    endtask

    task automatic test_random_profiles();
        int          ph, k, n_eff, n_fill;
        int unsigned r;
        longint      step_max, cur;
        logic        scramble;
        logic [7:0]  slot;
        logic [31:0] span_lo, span_hi, f_low, f_high, probe;
        for (ph = 0; ph < 18; ph++) begin
            if (ph < 6) begin
                send_idle_pct = 32;
                recv_idle_pct = 66;
            end else if (ph < 12) begin
                send_idle_pct = 66;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            n_eff    = (phase_plan[ph] > MAX_POINTS) ? MAX_POINTS : phase_plan[ph];
            n_fill   = (n_eff > 32) ? 24 : n_eff;
            scramble = ($urandom_range(4) == 0);
            case ($urandom_range(2))
                0: step_max = 50;
                1: step_max = 100000;
                default: step_max = 64'hFFFF_FFFF / (n_fill + 1);
            endcase
            cur = $urandom_range(32'(64'hFFFF_FFFF - n_fill * step_max), 0);

            // load a rising sweep of points
            phase_freqs.delete();
            for (k = 0; k < n_fill; k++) begin
                slot = (n_eff > 32 || scramble) ? 8'($urandom_range(n_eff - 1)) : 8'(k);
                phase_freqs.push_back(cur[31:0]);
                write_point(slot, cur[31:0], random_point_vals(), $urandom_range(99) < 85);
                cur += $urandom_range(32'(step_max), 0);
            end
            if (phase_freqs.size() == 0) begin
                span_lo = 32'd0;
                span_hi = FREQ_TOP;
            end else begin
                span_lo = phase_freqs[0];
                span_hi = phase_freqs[phase_freqs.size() - 1];
            end

            r = $urandom_range(99);
            if (r < 65) begin
                f_low  = (span_lo > 100) ? span_lo - $urandom_range(100) : 32'd0;
                f_high = (span_hi < FREQ_TOP - 100) ? span_hi + $urandom_range(100) : FREQ_TOP;
            end else if (r < 85) begin
                f_low  = 32'd0;
                f_high = FREQ_TOP;
            end else begin
                f_low  = span_hi;
                f_high = span_lo;
            end
            set_regs(PCNT_W'(phase_plan[ph]), f_low, f_high, $urandom_range(3) == 0);

            for (k = 0; k < 22; k++) begin
                if ($urandom_range(29) == 0) wait_drained();
                r = $urandom_range(99);
                if (r < 6 && n_eff > 0) begin
                    write_point(8'($urandom_range(n_eff - 1)), $urandom_range(span_hi, span_lo),
                                random_point_vals(), r < 5);
                end else if (r < 55) begin
                    query_at($urandom_range(span_hi, span_lo));
                end else if (r < 72 && phase_freqs.size() > 0) begin
                    query_at(phase_freqs[$urandom_range(phase_freqs.size() - 1)]);
                end else if (r < 82) begin
                    case ($urandom_range(3))
                        0: probe = lim_f_low;
                        1: probe = lim_f_high;
                        2: probe = lim_f_low - 1;
                        default: probe = lim_f_high + 1;
                    endcase
                    query_at(probe);
                end else begin
                    query_at($urandom);
                end
            end
        end
    endtask

    initial begin
        foreach (pt_valid[i]) begin
            pt_valid[i] = 1'b0;
            pt_freq[i]  = '0;
            pt_vals[i]  = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 32;
        recv_idle_pct = 66;

        test_empty_table();
        test_lookup_cases();
        test_range_and_neighbours();
        test_register_handling();
        test_random_profiles();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
